/* hdl/deq_pkg.sv */
// ----------------------------------------------------------------------------
// Deque package
// Shared types and constants of the double-ended queue core, its channel
// interfaces and its checker.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Field widths of the channels.
  localparam int WORD_W  = 64;
  localparam int REQ_W   = 3;
  localparam int OCC_W   = 5;
  localparam int RUN_MAX = 16;
  localparam int CNT_W   = 5;

  // Request codes; codes 6 and 7 are unused and only answer with ok.
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_TAIL = 3'd0,
    REQ_PUSH_HEAD = 3'd1,
    REQ_POP_HEAD  = 3'd2,
    REQ_DELETE    = 3'd3,
    REQ_CLEAR     = 3'd4,
    REQ_DRAIN     = 3'd5
  } req_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // Control sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_OUT,
    S_DEL_CMP,
    S_SHIFT,
    S_DRAIN_OUT,
    S_EMIT
  } state_t;

endpackage

/* hdl/deq_if.sv */
// ----------------------------------------------------------------------------
// Deque channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------

// Request channel: one request type and one data word per item.
interface deq_in_if import deq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [WORD_W-1:0] data_word;

  modport source (output valid, req_type, data_word, input ready);
  modport sink   (input valid, req_type, data_word, output ready);
endinterface

// Result channel: word, status, run end flag and occupancy per item.
interface deq_out_if import deq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] out_word;
  logic [1:0]        status;
  logic              last;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, out_word, status, last, occupancy, input ready);
  modport sink   (input valid, out_word, status, last, occupancy, output ready);
endinterface

/* hdl/deq_ram.sv */
// ----------------------------------------------------------------------------
// Deque RAM
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/double_ended_queue_with_delete_core.sv */
// ----------------------------------------------------------------------------
// Double-ended queue core with delete
// Circular deque of 64-bit words held in one RAM, with push at either end,
// pop at the head, delete by value, clear and drain.
// ----------------------------------------------------------------------------
// The core takes one request item at a time. Push, clear, rejected requests
// and unused codes are answered from the idle state; pop waits in a further
// state, since the word comes out of the RAM's registered read port. A delete
// compares one entry per cycle from the head and then moves each later entry
// one place toward the head, one per cycle. A drain emits up to 16 words, one
// per cycle after a first read while the result channel is free, as a run
// whose last item carries last = 1; every item of the run reports the
// occupancy left after the whole drain. A push to a full queue answers status
// full, a pop or drain of an empty queue answers status empty, and a delete
// that finds no match answers status not found. Result stalls simply hold
// the core in place.
module double_ended_queue_with_delete_core import deq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  deq_in_if.sink    in_chan,
  deq_out_if.source out_chan
);

  localparam int PW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int WW = (FW > CNT_W) ? FW : CNT_W;

  // Control and pointer registers.
  state_t          state_r, state_nxt;
  logic [PW-1:0]   front_r, front_nxt;
  logic [PW-1:0]   back_r, back_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic [PW-1:0]   pos_r, pos_nxt;
  logic [FW-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  status_t         pend_r, pend_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;
  logic [OCC_W-1:0]  out_occ_r, out_occ_nxt;

  // RAM ports.
  logic              wr_en, rd_en;
  logic [PW-1:0]     wr_addr, rd_addr;
  logic [WORD_W-1:0] wr_data, rd_data;

  // Helpers.
  logic              out_free, in_fire, full, empty;
  logic              ld;
  logic [WORD_W-1:0] ld_word;
  status_t           ld_status;
  logic              ld_last;
  logic [WW-1:0]     fill_w;
  logic [CNT_W-1:0]  run_len;
  logic [FW:0]       idx_p1, idx_p2, fill_x;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_prev(input logic [PW-1:0] p);
    return (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
  endfunction

  deq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Handshake and status terms.
  assign out_free      = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE) && out_free;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign full          = (fill_r == FW'(DEPTH));
  assign empty         = (fill_r == '0);
  assign fill_w        = WW'(fill_r);
  assign run_len       = (fill_w > WW'(RUN_MAX)) ? CNT_W'(RUN_MAX) : CNT_W'(fill_w);
  assign idx_p1        = {1'b0, idx_r} + 1'b1;
  assign idx_p2        = {1'b0, idx_r} + 2'd2;
  assign fill_x        = {1'b0, fill_r};

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_word  = out_word_r;
  assign out_chan.status    = out_status_r;
  assign out_chan.last      = out_last_r;
  assign out_chan.occupancy = out_occ_r;

  // Sequencer: next state, pointer updates, RAM accesses and result loads.
  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    back_nxt  = back_r;
    fill_nxt  = fill_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    word_nxt  = word_r;
    pend_nxt  = pend_r;
    wr_en     = 1'b0;
    wr_addr   = back_r;
    wr_data   = in_chan.data_word;
    rd_en     = 1'b0;
    rd_addr   = front_r;
    ld        = 1'b0;
    ld_word   = '0;
    ld_status = ST_OK;
    ld_last   = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_chan.req_type)
            REQ_PUSH_TAIL: begin
              ld = 1'b1;
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = back_r;
                back_nxt = ptr_next(back_r);
                fill_nxt = fill_r + 1'b1;
              end
            end
            REQ_PUSH_HEAD: begin
              ld = 1'b1;
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = ptr_prev(front_r);
                front_nxt = ptr_prev(front_r);
                fill_nxt  = fill_r + 1'b1;
              end
            end
            REQ_POP_HEAD: begin
              if (empty) begin
                ld        = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                front_nxt = ptr_next(front_r);
                fill_nxt  = fill_r - 1'b1;
                state_nxt = S_POP_OUT;
              end
            end
            REQ_DELETE: begin
              if (empty) begin
                ld        = 1'b1;
                ld_status = ST_MISSING;
              end else begin
                rd_en     = 1'b1;
                pos_nxt   = front_r;
                idx_nxt   = '0;
                word_nxt  = in_chan.data_word;
                state_nxt = S_DEL_CMP;
              end
            end
            REQ_CLEAR: begin
              ld        = 1'b1;
              front_nxt = '0;
              back_nxt  = '0;
              fill_nxt  = '0;
            end
            REQ_DRAIN: begin
              if (empty) begin
                ld        = 1'b1;
                ld_status = ST_EMPTY;
                front_nxt = '0;
                back_nxt  = '0;
              end else begin
                rd_en     = 1'b1;
                cnt_nxt   = run_len;
                fill_nxt  = fill_r - FW'(run_len);
                state_nxt = S_DRAIN_OUT;
              end
            end
            default: begin
              ld = 1'b1;
            end
          endcase
        end
      end

      // The popped word sits in the RAM read register.
      S_POP_OUT: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_word   = rd_data;
          state_nxt = S_IDLE;
        end
      end

      // Compare one held entry per cycle, walking from the head.
      S_DEL_CMP: begin
        if (rd_data == word_r) begin
          if (idx_p1 < fill_x) begin
            rd_en     = 1'b1;
            rd_addr   = ptr_next(pos_r);
            state_nxt = S_SHIFT;
          end else begin
            back_nxt  = ptr_prev(back_r);
            fill_nxt  = fill_r - 1'b1;
            pend_nxt  = ST_OK;
            state_nxt = S_EMIT;
          end
        end else if (idx_p1 == fill_x) begin
          pend_nxt  = ST_MISSING;
          state_nxt = S_EMIT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = ptr_next(pos_r);
          pos_nxt   = ptr_next(pos_r);
          idx_nxt   = idx_r + 1'b1;
        end
      end

      // Close the gap: write the entry read from the next slot, read ahead.
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = pos_r;
        wr_data = rd_data;
        pos_nxt = ptr_next(pos_r);
        idx_nxt = idx_r + 1'b1;
        if (idx_p2 < fill_x) begin
          rd_en   = 1'b1;
          rd_addr = ptr_next(ptr_next(pos_r));
        end else begin
          back_nxt  = ptr_prev(back_r);
          fill_nxt  = fill_r - 1'b1;
          pend_nxt  = ST_OK;
          state_nxt = S_EMIT;
        end
      end

      // Emit one drained word per cycle while the output is free.
      S_DRAIN_OUT: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_word = rd_data;
          ld_last = (cnt_r == CNT_W'(1));
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
            if (fill_r == '0) begin
              front_nxt = '0;
              back_nxt  = '0;
            end else begin
              front_nxt = ptr_next(front_r);
            end
          end else begin
            rd_en     = 1'b1;
            rd_addr   = ptr_next(front_r);
            front_nxt = ptr_next(front_r);
          end
        end
      end

      // Single result of a delete.
      S_EMIT: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_status = pend_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register next values.
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_word_nxt   = out_word_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    out_occ_nxt    = out_occ_r;
    if (ld) begin
      out_valid_nxt  = 1'b1;
      out_word_nxt   = ld_word;
      out_status_nxt = ld_status;
      out_last_nxt   = ld_last;
      out_occ_nxt    = OCC_W'(fill_nxt);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      back_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    word_r       <= word_nxt;
    pend_r       <= pend_nxt;
    out_word_r   <= out_word_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    out_occ_r    <= out_occ_nxt;
  end

endmodule

/* hdl/deq_checker.sv */
// ----------------------------------------------------------------------------
// Deque checker
// Port-level assertions on the result channel of the deque core.
// ----------------------------------------------------------------------------
module deq_checker import deq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] out_word,
  input logic [1:0]        status,
  input logic              last,
  input logic [OCC_W-1:0]  occupancy
);

  // A stalled result item holds its word.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled result item changed");

  // Only a successful item carries a word.
  a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_OK) |-> (out_word == '0))
    else $error("failed request returned a nonzero word");

  // Only a drain run has items without the last flag, and those succeed.
  a_run_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last |-> (status == ST_OK))
    else $error("open run item with a failure status");

  // A full rejection reports a full queue, an empty one reports zero.
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((status != ST_FULL) || (occupancy == OCC_W'(DEPTH))) &&
                  ((status != ST_EMPTY) || (occupancy == '0)))
    else $error("occupancy does not match the status");

endmodule

bind double_ended_queue_with_delete_core deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_word  (out_chan.out_word),
  .status    (out_chan.status),
  .last      (out_chan.last),
  .occupancy (out_chan.occupancy)
);

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// Deque core testbench
// Drives request items into the double-ended queue core and checks every
// result item against a queue-based predictor of the deque contents. A short
// table of directed requests covers the empty, full, not-found and unused-code
// cases. Random requests follow, grouped into grow, shrink and even phases,
// with random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module testbench import deq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 16;
  localparam int RAND_ITEMS   = 205;
  localparam int QUIET_ITEMS  = 35;
  localparam int BACKLOG_AT   = 60;
  localparam int BACKLOG_CYC  = 150;
  localparam int SETTLE_CYC   = 40;
  localparam int REPORT_MAX   = 10;

  // Request codes that the core answers with a plain ok.
  localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

  // Phases of the random request mix.
  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

  typedef struct {
    logic [WORD_W-1:0] word;
    status_t           status;
    logic              last;
    logic [OCC_W-1:0]  occupancy;
  } result_t;

  // One request of the directed table; want is used only when given is set.
  typedef struct {
    logic [REQ_W-1:0]  req;
    logic [WORD_W-1:0] data;
    bit                given;
    result_t           want;
  } plan_row_t;

  // Typed-in answer travelling along with each offered item.
  typedef struct {
    bit      given;
    result_t want;
  } typed_answer_t;

  logic clk = 1'b0;
  logic rst_n;

  deq_in_if  in_if ();
  deq_out_if out_if ();

  double_ended_queue_with_delete_core #(.DEPTH(DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  logic [WORD_W-1:0] deque_model[$];
  result_t           awaited_results[$];
  typed_answer_t     typed_answers[$];
  plan_row_t         directed_plan[$];
  logic [WORD_W-1:0] word_pool[DEPTH];

  int failures    = 0;
  int items_taken = 0;
  bit quiet_tail  = 1'b0;

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the results of one accepted request and updates the deque copy.
  function automatic void apply_request(input logic [REQ_W-1:0] req,
                                        input logic [WORD_W-1:0] data);
    result_t           res;
    logic [WORD_W-1:0] run_words[$];
    int                hit;
    int                run_len;
    hit            = -1;
    res.word       = '0;
    res.status     = ST_OK;
    res.last       = 1'b1;
    case (req)
      REQ_PUSH_TAIL: begin
        if (deque_model.size() >= DEPTH) res.status = ST_FULL;
        else deque_model.push_back(data);
      end
      REQ_PUSH_HEAD: begin
        if (deque_model.size() >= DEPTH) res.status = ST_FULL;
        else deque_model.push_front(data);
      end
      REQ_POP_HEAD: begin
        if (deque_model.size() == 0) res.status = ST_EMPTY;
        else res.word = deque_model.pop_front();
      end
      REQ_DELETE: begin
        // Only the first match from the head goes; later entries close up.
        for (int i = 0; i < deque_model.size(); i++) begin
          if (hit < 0 && deque_model[i] == data) hit = i;
        end
        if (hit < 0) res.status = ST_MISSING;
        else deque_model.delete(hit);
      end
      REQ_CLEAR: begin
        deque_model.delete();
      end
      REQ_DRAIN: begin
        if (deque_model.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          run_len = (deque_model.size() < RUN_MAX) ? deque_model.size() : RUN_MAX;
          for (int i = 0; i < run_len; i++) run_words.push_back(deque_model.pop_front());
          // Every item of the run carries the count left after the whole drain.
          for (int i = 0; i < run_len; i++) begin
            res.word      = run_words[i];
            res.last      = (i == run_len - 1);
            res.occupancy = OCC_W'(deque_model.size());
            awaited_results.push_back(res);
          end
          return;
        end
      end
      default: ;
    endcase
    res.occupancy = OCC_W'(deque_model.size());
    awaited_results.push_back(res);
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= REPORT_MAX) $display("%t: %s", $realtime, msg);
  endfunction

  // Compares one result item with the oldest expectation, field by field.
  function automatic void check_result(input result_t got);
    result_t want;
    if (awaited_results.size() == 0) begin
      note_failure($sformatf("unexpected result: word=%h status=%0d last=%b occ=%0d",
                             got.word, got.status, got.last, got.occupancy));
      return;
    end
    want = awaited_results.pop_front();
    if (got.word !== want.word || got.status !== want.status ||
        got.last !== want.last || got.occupancy !== want.occupancy) begin
      note_failure($sformatf({"mismatch: expected word=%h status=%0d last=%b occ=%0d,",
                              " got word=%h status=%0d last=%b occ=%0d"},
                             want.word, want.status, want.last, want.occupancy,
                             got.word, got.status, got.last, got.occupancy));
    end
  endfunction

  // Watches both channels; prediction runs before the check at each edge.
  always @(posedge clk) begin : watch
    typed_answer_t tag;
    result_t       got;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        tag = typed_answers.pop_front();
        apply_request(in_if.req_type, in_if.data_word);
        if (tag.given) begin
          void'(awaited_results.pop_back());
          awaited_results.push_back(tag.want);
        end
        items_taken++;
      end
      if (out_if.valid && out_if.ready) begin
        got.word      = out_if.out_word;
        got.status    = status_t'(out_if.status);
        got.last      = out_if.last;
        got.occupancy = out_if.occupancy;
        check_result(got);
      end
    end
  end

  // Offers one request item and waits until the core takes it.
  task automatic offer(input logic [REQ_W-1:0] req, input logic [WORD_W-1:0] data,
                       input bit given, input result_t want);
    typed_answer_t tag;
    tag.given = given;
    tag.want  = want;
    typed_answers.push_back(tag);
    in_if.valid     <= 1'b1;
    in_if.req_type  <= req;
    in_if.data_word <= data;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  function automatic void add_row(input logic [REQ_W-1:0] req,
                                  input logic [WORD_W-1:0] data, input bit given,
                                  input status_t status, input int occ);
    plan_row_t row;
    row.req            = req;
    row.data           = data;
    row.given          = given;
    row.want.word      = '0;
    row.want.status    = status;
    row.want.last      = 1'b1;
    row.want.occupancy = OCC_W'(occ);
    directed_plan.push_back(row);
  endfunction

  function automatic logic [REQ_W-1:0] pick_request(input mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (roll < 40) return REQ_PUSH_TAIL;
        if (roll < 78) return REQ_PUSH_HEAD;
        if (roll < 86) return REQ_POP_HEAD;
        if (roll < 93) return REQ_DELETE;
        if (roll < 97) return REQ_DRAIN;
      end
      MIX_SHRINK: begin
        if (roll < 10) return REQ_PUSH_TAIL;
        if (roll < 18) return REQ_PUSH_HEAD;
        if (roll < 50) return REQ_POP_HEAD;
        if (roll < 80) return REQ_DELETE;
        if (roll < 92) return REQ_DRAIN;
        if (roll < 96) return REQ_CLEAR;
      end
      default: begin
        if (roll < 25) return REQ_PUSH_TAIL;
        if (roll < 45) return REQ_PUSH_HEAD;
        if (roll < 65) return REQ_POP_HEAD;
        if (roll < 82) return REQ_DELETE;
        if (roll < 92) return REQ_DRAIN;
        if (roll < 96) return REQ_CLEAR;
      end
    endcase
    return ($urandom_range(0, 1) != 0) ? REQ_UNUSED_6 : REQ_UNUSED_7;
  endfunction

  // Picks a word: pushes and deletes often reuse recent words so that deletes
  // hit and duplicates exist; extremes show up now and then.
  function automatic logic [WORD_W-1:0] pick_word(input logic [REQ_W-1:0] req);
    int roll;
    roll = $urandom_range(0, 99);
    if (req == REQ_DELETE && roll < 70) return word_pool[$urandom_range(0, DEPTH - 1)];
    if ((req == REQ_PUSH_TAIL || req == REQ_PUSH_HEAD) && roll < 25)
      return word_pool[$urandom_range(0, DEPTH - 1)];
    if (roll < 30) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return {$urandom, $urandom};
  endfunction

  // Request side: directed table, then random phases.
  initial begin : requests
    result_t           none;
    logic [REQ_W-1:0]  req;
    logic [WORD_W-1:0] data;
    mix_t              mix;
    int                gap_pct;
    none = '{word: '0, status: ST_OK, last: 1'b1, occupancy: '0};
    mix     = MIX_EVEN;
    gap_pct = 0;
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.req_type  <= REQ_PUSH_TAIL;
    in_if.data_word <= '0;
    for (int i = 0; i < DEPTH; i++) word_pool[i] = {$urandom, $urandom};

    // Empty queue after reset, unused code, then fill to the brim.
    add_row(REQ_POP_HEAD, '0, 1'b1, ST_EMPTY, 0);
    add_row(REQ_DRAIN, '0, 1'b1, ST_EMPTY, 0);
    add_row(REQ_DELETE, '1, 1'b1, ST_MISSING, 0);
    add_row(REQ_UNUSED_6, 64'hC3C3_3C3C_A5A5_5A5A, 1'b1, ST_OK, 0);
    add_row(REQ_PUSH_TAIL, '0, 1'b0, ST_OK, 0);
    add_row(REQ_PUSH_HEAD, '1, 1'b0, ST_OK, 0);
    add_row(REQ_PUSH_TAIL, 64'h8000_0000_0000_0000, 1'b0, ST_OK, 0);
    add_row(REQ_PUSH_HEAD, 64'h0000_0000_0000_0001, 1'b0, ST_OK, 0);
    for (int i = 4; i < DEPTH; i++) begin
      add_row((i % 2 != 0) ? REQ_PUSH_HEAD : REQ_PUSH_TAIL,
              {16'hC0DE, 16'(i), 32'hF00D_0000 + i}, 1'b0, ST_OK, 0);
    end
    // Full queue rejects pushes at both ends.
    add_row(REQ_PUSH_TAIL, 64'h1111_2222_3333_4444, 1'b1, ST_FULL, DEPTH);
    add_row(REQ_PUSH_HEAD, 64'h5555_6666_7777_8888, 1'b1, ST_FULL, DEPTH);
    // Pop, delete from the middle, drain the rest, then clear a short queue.
    add_row(REQ_POP_HEAD, '0, 1'b0, ST_OK, 0);
    add_row(REQ_DELETE, 64'h8000_0000_0000_0000, 1'b0, ST_OK, 0);
    add_row(REQ_DRAIN, '0, 1'b0, ST_OK, 0);
    add_row(REQ_PUSH_TAIL, 64'hFEED_FACE_CAFE_BEEF, 1'b0, ST_OK, 0);
    add_row(REQ_CLEAR, '0, 1'b1, ST_OK, 0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[i])
      offer(directed_plan[i].req, directed_plan[i].data, directed_plan[i].given,
            directed_plan[i].want);

    // Random phases of 24 items, each with its own mix and idling rate.
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k % 24 == 0) begin
        mix = mix_t'($urandom_range(0, 2));
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 20;
          default: gap_pct = 45;
        endcase
      end
      if (k >= RAND_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
      req  = pick_request(mix);
      data = pick_word(req);
      if (req == REQ_PUSH_TAIL || req == REQ_PUSH_HEAD)
        word_pool[$urandom_range(0, DEPTH - 1)] = data;
      if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      offer(req, data, 1'b0, none);
    end
    in_if.valid <= 1'b0;

    // Let every expected result arrive, then give the core time to misbehave.
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (failures == 0 && awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: random stall bursts, one long backlog, none near the end.
  initial begin : results
    int  stall_pct;
    bit  backlog_done;
    stall_pct    = 0;
    backlog_done = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          default: stall_pct = 50;
        endcase
      end
      if (!backlog_done && items_taken >= BACKLOG_AT) begin
        // Hold off long enough for the core to back up and stall its input.
        backlog_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (BACKLOG_CYC) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
hdl/deq_pkg.sv
hdl/deq_if.sv
hdl/deq_ram.sv
hdl/double_ended_queue_with_delete_core.sv
hdl/deq_checker.sv
tb/sv/testbench.sv
